/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/ddfs_pkg.sv */
// ----------------------------------------------------------------------------
// ddfs_pkg
// Types and constants shared by the display fade sequencer modules.
// ----------------------------------------------------------------------------
package ddfs_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int CODE_W     = 4;
  localparam int CHAR_W     = 8;
  localparam int BRIGHT_W   = 8;

  localparam logic [CODE_W-1:0]   CODE_DOT   = 4'd10;
  localparam logic [CODE_W-1:0]   CODE_BLANK = 4'd11;
  localparam logic [CHAR_W-1:0]   ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0]   ASCII_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0]   ASCII_SPC  = 8'h20;
  localparam logic [BRIGHT_W-1:0] FULL       = 8'hFF;
  localparam logic [BRIGHT_W-1:0] DARK       = 8'h00;

  typedef logic [NUM_DIGITS-1:0][CODE_W-1:0]   code_arr_t;
  typedef logic [NUM_DIGITS-1:0][CHAR_W-1:0]   char_arr_t;
  typedef logic [NUM_DIGITS-1:0][BRIGHT_W-1:0] bright_arr_t;

  // Item kind carried in tuser.
  typedef enum logic {
    KIND_SET  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // Per-digit fade move.
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_UP        = 2'd1,
    PH_DOWN_UP   = 2'd2,
    PH_DOWN_ONLY = 2'd3
  } digit_phase_t;

  // Shared ramp-following phase.
  typedef enum logic [1:0] {
    LP_WAIT = 2'd0,
    LP_DOWN = 2'd1,
    LP_UP   = 2'd2
  } loop_phase_t;

  // Decoded set-text characters.
  typedef struct packed {
    code_arr_t code;
    logic      ok;
  } dec_t;

  // One result transaction.
  typedef struct packed {
    code_arr_t   code;
    bright_arr_t bright;
    logic        latch_pulse;
    logic        accepted;
    logic        busy_res;
  } res_t;

endpackage

/* sv/ddfs_decode.sv */
// ----------------------------------------------------------------------------
// ddfs_decode
// Maps the four ASCII characters to tube codes and flags invalid ones.
// ----------------------------------------------------------------------------
module ddfs_decode (
  input  ddfs_pkg::char_arr_t chars,
  output ddfs_pkg::dec_t      dec
);
  import ddfs_pkg::*;

  // Per-digit lookup; any character outside the set clears ok.
  always_comb begin
    dec.ok = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dec.code[i] = CODE_BLANK;
      if (chars[i] inside {[ASCII_ZERO:ASCII_ZERO + 8'd9]}) begin
        dec.code[i] = CODE_W'(chars[i] - ASCII_ZERO);
      end else if (chars[i] == ASCII_SPC) begin
        dec.code[i] = CODE_BLANK;
      end else if (chars[i] == ASCII_DOT) begin
        dec.code[i] = CODE_DOT;
      end else begin
        dec.ok = 1'b0;
      end
    end
  end

endmodule

/* sv/ddfs_seq.sv */
// ----------------------------------------------------------------------------
// ddfs_seq
// Display state and the fade sequencer; computes the result of each item.
// ----------------------------------------------------------------------------
module ddfs_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         fade_mode,
  input  ddfs_pkg::kind_t              kind,
  input  ddfs_pkg::dec_t               dec,
  input  logic [ddfs_pkg::BRIGHT_W-1:0] ramp_sample,
  input  logic                         ramp_falling,
  output ddfs_pkg::res_t               res_next,
  output logic                         pending
);
  import ddfs_pkg::*;

  code_arr_t    target, target_next;
  code_arr_t    driven, driven_next;
  bright_arr_t  bright, bright_next;
  digit_phase_t phase [NUM_DIGITS];
  digit_phase_t phase_next [NUM_DIGITS];
  loop_phase_t  loop_ph, loop_ph_next;
  logic         pending_next;
  logic         latch;
  logic         acc;

  // Next state for one item.
  always_comb begin
    target_next  = target;
    driven_next  = driven;
    bright_next  = bright;
    phase_next   = phase;
    loop_ph_next = loop_ph;
    pending_next = pending;
    latch        = 1'b0;
    acc          = 1'b0;

    if (kind == KIND_SET) begin
      if (dec.ok && !pending) begin
        acc = 1'b1;
        if (!fade_mode) begin
          // Instant update: drive and latch at once.
          for (int i = 0; i < NUM_DIGITS; i++) begin
            target_next[i] = dec.code[i];
            driven_next[i] = dec.code[i];
            bright_next[i] = (dec.code[i] == CODE_BLANK) ? DARK : FULL;
          end
          latch = 1'b1;
        end else begin
          // Fade update: mark changed digits with their move.
          for (int i = 0; i < NUM_DIGITS; i++) begin
            if (target[i] != dec.code[i]) begin
              if (target[i] == CODE_BLANK) begin
                phase_next[i] = PH_UP;
              end else if (dec.code[i] == CODE_BLANK) begin
                phase_next[i] = PH_DOWN_ONLY;
              end else begin
                phase_next[i] = PH_DOWN_UP;
              end
              target_next[i] = dec.code[i];
            end
          end
          pending_next = 1'b1;
        end
      end
    end else if (pending) begin
      case (loop_ph)
        LP_WAIT: begin
          if (ramp_falling && ramp_sample == FULL) begin
            loop_ph_next = LP_DOWN;
          end
        end
        LP_DOWN: begin
          // Follow the ramp down; swap codes and latch at zero.
          for (int i = 0; i < NUM_DIGITS; i++) begin
            if (phase[i] == PH_DOWN_UP || phase[i] == PH_DOWN_ONLY) begin
              bright_next[i] = ramp_sample;
            end
            if (ramp_sample == DARK) begin
              driven_next[i] = target[i];
              if (phase[i] == PH_DOWN_UP) begin
                phase_next[i] = PH_UP;
              end else if (phase[i] == PH_DOWN_ONLY) begin
                phase_next[i] = PH_DOWN_UP;
              end
            end
          end
          if (ramp_sample == DARK) begin
            latch        = 1'b1;
            loop_ph_next = LP_UP;
          end
        end
        LP_UP: begin
          // Follow the ramp up; finish at full brightness.
          for (int i = 0; i < NUM_DIGITS; i++) begin
            if (phase[i] == PH_UP) begin
              bright_next[i] = ramp_sample;
            end
            if (ramp_sample == FULL) begin
              phase_next[i] = PH_IDLE;
            end
          end
          if (ramp_sample == FULL) begin
            loop_ph_next = LP_WAIT;
            pending_next = 1'b0;
          end
        end
        default: begin
          loop_ph_next = LP_WAIT;
        end
      endcase
    end

    res_next.code        = driven_next;
    res_next.bright      = bright_next;
    res_next.latch_pulse = latch;
    res_next.accepted    = acc;
    res_next.busy_res    = pending_next;
  end

  // State registers, updated once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        target[i] <= CODE_BLANK;
        driven[i] <= CODE_BLANK;
        bright[i] <= DARK;
        phase[i]  <= PH_IDLE;
      end
      loop_ph <= LP_WAIT;
      pending <= 1'b0;
    end else if (step) begin
      target  <= target_next;
      driven  <= driven_next;
      bright  <= bright_next;
      phase   <= phase_next;
      loop_ph <= loop_ph_next;
      pending <= pending_next;
    end
  end

endmodule

/* sv/digit_display_fade_sequencer_top.sv */
// ----------------------------------------------------------------------------
// digit_display_fade_sequencer_top
// Four-tube display driver with instant or ramp-following fade updates.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: kind; tdata: char_0..3, ramp_sample, ramp_falling
//  m_axis    out        tdata: code_0..3, bright_0..3, latch_pulse, accepted, busy_res
//  cfg       in         cfg_we / cfg_wdata: fade_mode
//
//  One transaction in, one result out, one per cycle sustained while m_axis_tready stays high.
//  The path runs through the input register, then the sequencer into the result register.
//  The state feedback runs through the sequencer and its own registers, which sets the rate.
//  Reset (rst, synchronous) blanks all tubes, clears brightness and leaves instant mode.
//  A stalled result holds the output register; the input register fills, then tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module digit_display_fade_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  // Configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // char_0, char_1, char_2, char_3, ramp_sample,
                                     // ramp_falling, zero fill
  input  logic [0:0]  s_axis_tuser,  // kind
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // code_0..code_3, bright_0..bright_3,
                                     // latch_pulse, accepted, busy_res, zero fill
);
  import ddfs_pkg::*;

  logic                fade_mode;
  logic                in_valid;
  kind_t               in_kind;
  char_arr_t           in_chars;
  logic [BRIGHT_W-1:0] in_ramp;
  logic                in_falling;
  logic                out_valid;
  res_t                out_res;
  res_t                res_next;
  dec_t                dec;
  logic                adv;
  logic                pending;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_mode <= 1'b0;
    end else if (cfg_we) begin
      fade_mode <= cfg_wdata;
    end
  end

  // Pipeline handshake.
  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind    <= kind_t'(s_axis_tuser[0]);
      in_chars   <= s_axis_tdata[31:0];
      in_ramp    <= s_axis_tdata[39:32];
      in_falling <= s_axis_tdata[40];
    end
  end

  // Character decode and sequencer.
  ddfs_decode u_decode (
    .chars (in_chars),
    .dec   (dec)
  );

  ddfs_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (adv),
    .fade_mode    (fade_mode),
    .kind         (in_kind),
    .dec          (dec),
    .ramp_sample  (in_ramp),
    .ramp_falling (in_falling),
    .res_next     (res_next),
    .pending      (pending)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid        = out_valid;
  assign m_axis_tdata[15:0]   = out_res.code;
  assign m_axis_tdata[47:16]  = out_res.bright;
  assign m_axis_tdata[48]     = out_res.latch_pulse;
  assign m_axis_tdata[49]     = out_res.accepted;
  assign m_axis_tdata[50]     = out_res.busy_res;
  assign m_axis_tdata[55:51]  = 5'd0;

  // A latch always comes from an accepted request or from inside a fade.
  `ASSERT_IMPLY(a_latch_src, clk, rst, out_valid && out_res.latch_pulse, out_res.accepted || out_res.busy_res)
  // A request arriving during a fade is rejected.
  `ASSERT_NEXT(a_busy_reject, clk, rst, adv && in_kind == KIND_SET && pending, !out_res.accepted)
  // A held input transaction is not dropped while the output stalls.
  `ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !adv, in_valid)

endmodule
